[rtl/qte_pkg.sv]
// qte_pkg: shared types, constants and helper functions for the quaternion to euler block
// no dependencies
`timescale 1ns / 1ps

package qte_pkg;

    localparam int QUAT_W     = 18;
    localparam int PROD_W     = 36;
    localparam int SUM_W      = 38;
    localparam int ANG_OUT_W  = 16;
    localparam int ANG_W      = 32;
    localparam int CW         = 41;
    localparam int ARG_W      = 33;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;
    localparam int SQRT_STEPS = 32;
    localparam int ATAN_LEN   = 24;

    localparam logic signed [SUM_W-1:0]     ONE_Q32      = SUM_W'(64'sd4294967296);
    localparam logic signed [SUM_W-1:0]     NEG_ONE_Q32  = -ONE_Q32;
    localparam logic [ANG_W-1:0]            QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [ANG_OUT_W-1:0] PITCH_SAT    = 16'sd16384;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANG_W-1:0]     z;
        logic                 zero;
        logic                 clamp;
        logic                 neg;
    } cordic_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_num;
        logic signed [SUM_W-1:0] roll_den;
        logic signed [SUM_W-1:0] yaw_num;
        logic signed [SUM_W-1:0] yaw_den;
        logic signed [ARG_W-1:0] arg;
        logic                    clamp;
        logic                    neg;
    } side_t;

    // quarter-turn pre-rotation so that x is non-negative
    function automatic cordic_t prerot(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
        cordic_t c;
        c.zero  = (x == '0) && (y == '0);
        c.clamp = 1'b0;
        c.neg   = 1'b0;
        c.x     = x;
        c.y     = y;
        c.z     = '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                c.z = QUARTER_TURN;
                c.x = y;
                c.y = -x;
            end
            else
            begin
                c.z = -QUARTER_TURN;
                c.x = -y;
                c.y = x;
            end
        end
        return c;
    endfunction

    function automatic logic signed [ANG_OUT_W-1:0] round_angle(input logic [ANG_W-1:0] z);
        logic [ANG_W-1:0] t;
        t = z + ANG_W'(32768);
        return t[ANG_W-1 -: ANG_OUT_W];
    endfunction

endpackage

[rtl/qte_if.sv]
// qte_if: valid/ready channels for quaternion input and euler angle output
// depends on qte_pkg
`timescale 1ns / 1ps

interface qte_in_if;
    import qte_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
    import qte_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [ANG_OUT_W-1:0] roll_angle;
    logic signed [ANG_OUT_W-1:0] pitch_angle;
    logic signed [ANG_OUT_W-1:0] yaw_angle;
    logic                        pitch_clamped;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

[rtl/qte_sqrt_cell.sv]
// qte_sqrt_cell: one bit of a pipelined integer square root
// depends on qte_pkg
`timescale 1ns / 1ps

module qte_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  qte_pkg::sqrt_t d_in,
    output qte_pkg::sqrt_t d_out
);
    import qte_pkg::*;

    sqrt_t                d_out_reg;
    sqrt_t                d_out_next;
    logic [REM_W+1:0]     cur;
    logic [REM_W+1:0]     trial;
    logic                 ge;

    always_comb
    begin
        cur   = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
        trial = {2'b00, d_in.root, 2'b01};
        ge    = (cur >= trial);
        d_out_next.rad  = {d_in.rad[RAD_W-3:0], 2'b00};
        d_out_next.root = {d_in.root[ROOT_W-2:0], ge};
        d_out_next.rem  = ge ? REM_W'(cur - trial) : REM_W'(cur);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_out_reg <= d_out_next;
        end
    end

    assign d_out = d_out_reg;

endmodule

[rtl/qte_cordic_cell.sv]
// qte_cordic_cell: one vectoring rotation of a pipelined cordic arctangent
// depends on qte_pkg
`timescale 1ns / 1ps

module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             en,
    input  qte_pkg::cordic_t c_in,
    output qte_pkg::cordic_t c_out
);
    import qte_pkg::*;

    cordic_t              c_out_reg;
    cordic_t              c_out_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = c_in.y >>> STAGE;
        dy = c_in.x >>> STAGE;
        c_out_next = c_in;
        if (c_in.y >= 0)
        begin
            c_out_next.x = c_in.x + dx;
            c_out_next.y = c_in.y - dy;
            c_out_next.z = c_in.z + ATAN_TAB[STAGE];
        end
        else
        begin
            c_out_next.x = c_in.x - dx;
            c_out_next.y = c_in.y + dy;
            c_out_next.z = c_in.z - ATAN_TAB[STAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_out_reg <= c_out_next;
        end
    end

    assign c_out = c_out_reg;

endmodule

[rtl/quaternion_to_euler_angles.sv]
// path: products, sums, clamp detect, radicand, square root cells, pre-rotation, cordic cells, output register
// throughput: one quaternion per cycle; all stages advance together and hold
// only while a finished result waits at the output register
// the 32-cell square root chain and the cordic cell chains set the depth
// reset: rst_n clears all valid bits asynchronously; payload registers are not reset
`timescale 1ns / 1ps

module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    qte_in_if.sink   quat,
    qte_out_if.source euler
);
    import qte_pkg::*;

    localparam int DEPTH = 4 + SQRT_STEPS + 1 + CORDIC_STEPS;

    logic             en;
    logic [DEPTH-1:0] valid_reg;
    logic             out_valid_reg;

    // stage 1: products
    logic signed [PROD_W-1:0] p_wy_reg, p_xz_reg, p_xy_reg, p_zw_reg, p_yz_reg;
    logic signed [PROD_W-1:0] p_xw_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    // stage 2: sums
    side_t                    s2_side_reg;
    logic signed [SUM_W-1:0]  s2_arg_reg;
    logic signed [SUM_W-1:0]  s2_arg_next;
    // stage 3: clamp detect and magnitude
    side_t                    s3_side_reg;
    side_t                    s3_side_next;
    logic [ROOT_W-1:0]        s3_mag_reg;
    logic [ROOT_W-1:0]        s3_mag_next;
    // stage 4: radicand
    side_t                    s4_side_reg;
    logic [RAD_W-1:0]         s4_rad_reg;
    sqrt_t                    sq_chain [SQRT_STEPS+1];
    side_t                    side_line_reg [SQRT_STEPS];
    // pre-rotation and cordic chains: roll, pitch, yaw
    cordic_t                  roll_chain  [CORDIC_STEPS+1];
    cordic_t                  pitch_chain [CORDIC_STEPS+1];
    cordic_t                  yaw_chain   [CORDIC_STEPS+1];
    cordic_t                  roll_pr_reg, pitch_pr_reg, yaw_pr_reg;
    cordic_t                  pitch_pr_next;
    side_t                    side_last;
    logic signed [ANG_OUT_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                        clamp_reg;
    logic signed [ANG_OUT_W-1:0] pitch_next;
    cordic_t                     pitch_end;

    assign en         = !out_valid_reg || euler.ready;
    assign quat.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[DEPTH-2:0], quat.valid};
            out_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    always_comb
    begin
        s2_arg_next = SUM_W'(p_wy_reg - p_xz_reg) <<< 1;
        s3_mag_next = s2_arg_reg[SUM_W-1] ? ROOT_W'(-s2_arg_reg) : ROOT_W'(s2_arg_reg);
        s3_side_next       = s2_side_reg;
        s3_side_next.arg   = ARG_W'(s2_arg_reg);
        s3_side_next.clamp = (s2_arg_reg >= ONE_Q32) || (s2_arg_reg <= NEG_ONE_Q32);
        s3_side_next.neg   = s2_arg_reg[SUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wy_reg <= quat.quat_w * quat.quat_y;
            p_xz_reg <= quat.quat_x * quat.quat_z;
            p_xy_reg <= quat.quat_x * quat.quat_y;
            p_zw_reg <= quat.quat_z * quat.quat_w;
            p_yz_reg <= quat.quat_y * quat.quat_z;
            p_xw_reg <= quat.quat_x * quat.quat_w;
            p_xx_reg <= quat.quat_x * quat.quat_x;
            p_yy_reg <= quat.quat_y * quat.quat_y;
            p_zz_reg <= quat.quat_z * quat.quat_z;

            s2_side_reg.yaw_num  <= SUM_W'(p_xy_reg + p_zw_reg) <<< 1;
            s2_side_reg.roll_num <= SUM_W'(p_yz_reg + p_xw_reg) <<< 1;
            s2_side_reg.yaw_den  <= ONE_Q32 - (SUM_W'(p_yy_reg + p_zz_reg) <<< 1);
            s2_side_reg.roll_den <= ONE_Q32 - (SUM_W'(p_xx_reg + p_yy_reg) <<< 1);
            s2_side_reg.arg      <= '0;
            s2_side_reg.clamp    <= 1'b0;
            s2_side_reg.neg      <= 1'b0;
            s2_arg_reg           <= s2_arg_next;

            s3_side_reg <= s3_side_next;
            s3_mag_reg  <= s3_mag_next;

            s4_side_reg <= s3_side_reg;
            // 2^64 - a^2, wrapping
            s4_rad_reg  <= RAD_W'(0) - RAD_W'(s3_mag_reg * s3_mag_reg);

            side_line_reg[0] <= s4_side_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                side_line_reg[k] <= side_line_reg[k-1];
            end
        end
    end

    assign sq_chain[0].rem  = '0;
    assign sq_chain[0].root = '0;
    assign sq_chain[0].rad  = s4_rad_reg;

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            qte_sqrt_cell u_cell (
                .clk   (clk),
                .en    (en),
                .d_in  (sq_chain[g]),
                .d_out (sq_chain[g+1])
            );
        end
    endgenerate

    assign side_last = side_line_reg[SQRT_STEPS-1];

    always_comb
    begin
        pitch_pr_next       = prerot(CW'(side_last.arg),
                                     CW'({1'b0, sq_chain[SQRT_STEPS].root}));
        pitch_pr_next.clamp = side_last.clamp;
        pitch_pr_next.neg   = side_last.neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_pr_reg  <= prerot(CW'(side_last.roll_num), CW'(side_last.roll_den));
            yaw_pr_reg   <= prerot(CW'(side_last.yaw_num), CW'(side_last.yaw_den));
            pitch_pr_reg <= pitch_pr_next;
        end
    end

    assign roll_chain[0]  = roll_pr_reg;
    assign pitch_chain[0] = pitch_pr_reg;
    assign yaw_chain[0]   = yaw_pr_reg;

    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            qte_cordic_cell #(.STAGE(g)) u_roll (
                .clk   (clk),
                .en    (en),
                .c_in  (roll_chain[g]),
                .c_out (roll_chain[g+1])
            );
            qte_cordic_cell #(.STAGE(g)) u_pitch (
                .clk   (clk),
                .en    (en),
                .c_in  (pitch_chain[g]),
                .c_out (pitch_chain[g+1])
            );
            qte_cordic_cell #(.STAGE(g)) u_yaw (
                .clk   (clk),
                .en    (en),
                .c_in  (yaw_chain[g]),
                .c_out (yaw_chain[g+1])
            );
        end
    endgenerate

    assign pitch_end = pitch_chain[CORDIC_STEPS];

    always_comb
    begin
        if (pitch_end.clamp)
        begin
            pitch_next = pitch_end.neg ? -PITCH_SAT : PITCH_SAT;
        end
        else if (pitch_end.zero)
        begin
            pitch_next = '0;
        end
        else
        begin
            pitch_next = round_angle(pitch_end.z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_chain[CORDIC_STEPS].zero ? '0
                                                       : round_angle(roll_chain[CORDIC_STEPS].z);
            yaw_reg   <= yaw_chain[CORDIC_STEPS].zero ? '0
                                                      : round_angle(yaw_chain[CORDIC_STEPS].z);
            pitch_reg <= pitch_next;
            clamp_reg <= pitch_end.clamp;
        end
    end

    assign euler.valid         = out_valid_reg;
    assign euler.roll_angle    = roll_reg;
    assign euler.pitch_angle   = pitch_reg;
    assign euler.yaw_angle     = yaw_reg;
    assign euler.pitch_clamped = clamp_reg;

endmodule

[rtl/qte_checker.sv]
// qte_checker: port-level checks for quaternion_to_euler_angles, attached by bind
// depends on qte_pkg and the top level's channel ports
`timescale 1ns / 1ps

module qte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pitch_angle,
    input logic [15:0] roll_angle,
    input logic        pitch_clamped
);
    import qte_pkg::*;

    // the output register is cleared by reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // saturated pitch is exactly plus or minus a quarter turn
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pitch_clamped) |->
        (pitch_angle == 16'h4000 || pitch_angle == 16'hC000))
        else $error("clamped pitch not at quarter turn");

    // a waiting result stays valid and holds its pitch and roll angles
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(pitch_angle) && $stable(roll_angle)))
        else $error("stalled result changed");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (quat.ready),
    .out_valid     (euler.valid),
    .out_ready     (euler.ready),
    .pitch_angle   (euler.pitch_angle),
    .roll_angle    (euler.roll_angle),
    .pitch_clamped (euler.pitch_clamped)
);
